[hw/rtl/mwg_pkg.sv]
// Package for the multichannel waveform generator.
// Holds default sizes, register and waveform codes, the job record and the sine table builder.
// No dependencies.
package mwg_pkg;

    localparam int unsigned MWG_CHANNELS        = 4;
    localparam int unsigned MWG_PHASE_BITS      = 32;
    localparam int unsigned MWG_SAMPLE_BITS     = 12;
    localparam int unsigned MWG_SINE_TABLE_BITS = 8;
    localparam int unsigned MWG_QUEUE_DEPTH     = 4;

    typedef enum logic [2:0] {
        CFG_ACTIVE = 3'd0,
        CFG_WAVE   = 3'd1,
        CFG_INC0   = 3'd2,
        CFG_INC1   = 3'd3,
        CFG_INC2   = 3'd4,
        CFG_INC3   = 3'd5,
        CFG_START  = 3'd6
    } cfg_index_t;

    typedef enum logic [1:0] {
        WAVE_SINE   = 2'd0,
        WAVE_TRI    = 2'd1,
        WAVE_SAW    = 2'd2,
        WAVE_SQUARE = 2'd3
    } wave_t;

    typedef struct packed {
        logic [1:0]  channel;
        logic [31:0] phase;
        wave_t       sel;
        logic        last;
    } job_t;

    function automatic logic [63:0] sq_step(input logic [63:0] t, input logic [63:0] x);
        logic [63:0] r;
        r = (t * x) >> 30;
        r = (r * x) >> 30;
        return r;
    endfunction

    // Quarter-wave sine entry in Q1.30, Taylor series to x^13, evaluated at elaboration.
    function automatic logic [30:0] sine_entry(input int unsigned k, input int unsigned tb);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        x    = (64'd1686629713 * 64'(k)) >> tb;
        term = x;
        sum  = x;
        term = sq_step(term, x) / 64'd6;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = sq_step(term, x) / 64'd20;
        sum  = sum + term;
        term = sq_step(term, x) / 64'd42;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = sq_step(term, x) / 64'd72;
        sum  = sum + term;
        term = sq_step(term, x) / 64'd110;
        sum  = (sum >= term) ? sum - term : 64'd0;
        term = sq_step(term, x) / 64'd156;
        sum  = sum + term;
        return (sum > 64'h4000_0000) ? 31'h4000_0000 : sum[30:0];
    endfunction

endpackage

[hw/rtl/mwg_queue.sv]
// Short job queue between the front and the back of the waveform generator.
// Depends on mwg_pkg for the job record.
module mwg_queue
    import mwg_pkg::*;
#(
    parameter int unsigned DEPTH = MWG_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[hw/rtl/mwg_front.sv]
// Front of the waveform generator: configuration registers, tick intake and phase accumulators.
// Issues one job per active channel into the queue. Depends on mwg_pkg.
module mwg_front
    import mwg_pkg::*;
#(
    parameter int unsigned CHANNELS   = MWG_CHANNELS,
    parameter int unsigned PHASE_BITS = MWG_PHASE_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        tick_valid,
    output logic        tick_ready,
    input  logic        restart,
    output logic        push,
    output job_t        push_job,
    input  logic        full
);

    localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [2:0]            active_reg;
    logic [7:0]            wave_reg;
    logic [31:0]           inc_reg [4];
    logic [63:0]           start_reg;
    logic [PHASE_BITS-1:0] acc_reg [CHANNELS];
    logic                  busy_reg;
    logic                  busy_next;
    logic [1:0]            ch_reg;
    logic [1:0]            ch_next;

    logic [1:0]            last_ch;
    logic                  issue;
    logic                  issue_last;
    logic                  accept;
    logic [PHASE_BITS-1:0] acc_cur;
    logic [PHASE_BITS-1:0] acc_sum;
    logic [31:0]           phase32;
    logic [1:0]            inc_idx;

    always_comb
    begin
        if (active_reg == 3'd0)
        begin
            last_ch = 2'd0;
        end
        else if (active_reg > 3'(CHANNELS))
        begin
            last_ch = 2'(CHANNELS - 1);
        end
        else
        begin
            last_ch = 2'(active_reg - 3'd1);
        end
    end

    assign issue      = busy_reg && !full;
    assign issue_last = issue && (ch_reg == last_ch);
    assign tick_ready = !busy_reg || issue_last;
    assign accept     = tick_valid && tick_ready;
    assign push       = issue;

    assign acc_cur = acc_reg[ch_reg[IDX_W-1:0]];
    assign acc_sum = acc_cur + PHASE_BITS'(inc_reg[ch_reg]);

    generate
        if (PHASE_BITS >= 32)
        begin : g_wide
            assign phase32 = acc_cur[PHASE_BITS-1 -: 32];
        end
        else
        begin : g_narrow
            assign phase32 = 32'(acc_cur) << (32 - PHASE_BITS);
        end
    endgenerate

    always_comb
    begin
        push_job.channel = ch_reg;
        push_job.phase   = phase32;
        push_job.sel     = wave_t'(wave_reg[2*ch_reg +: 2]);
        push_job.last    = (ch_reg == last_ch);
    end

    always_comb
    begin
        busy_next = busy_reg;
        ch_next   = ch_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            ch_next   = 2'd0;
        end
        else if (issue_last)
        begin
            busy_next = 1'b0;
            ch_next   = 2'd0;
        end
        else if (issue)
        begin
            ch_next = ch_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ch_reg   <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            ch_reg   <= ch_next;
        end
    end

    // A restart reload overrides the advance of the channel issued in the same cycle.
    generate
        for (genvar c = 0; c < CHANNELS; c++)
        begin : g_acc
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    acc_reg[c] <= '0;
                end
                else if (accept && restart)
                begin
                    acc_reg[c] <= PHASE_BITS'(start_reg[16*c +: 16]) << (PHASE_BITS - 16);
                end
                else if (issue && (ch_reg[IDX_W-1:0] == IDX_W'(c)))
                begin
                    acc_reg[c] <= acc_sum;
                end
            end
        end
    endgenerate

    assign inc_idx = 2'(cfg_index - CFG_INC0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 3'd1;
            wave_reg   <= '0;
            inc_reg    <= '{default: '0};
            start_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ACTIVE: active_reg <= cfg_data[2:0];
                CFG_WAVE:   wave_reg   <= cfg_data[7:0];
                CFG_INC0, CFG_INC1, CFG_INC2, CFG_INC3:
                begin
                    inc_reg[inc_idx] <= cfg_data[31:0];
                end
                CFG_START:  start_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

endmodule

[hw/rtl/mwg_back.sv]
// Back of the waveform generator: three-stage pipeline from job to sample.
// Table lookup, waveform shaping, full-scale scaling with rounding. Depends on mwg_pkg.
module mwg_back
    import mwg_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS     = MWG_SAMPLE_BITS,
    parameter int unsigned SINE_TABLE_BITS = MWG_SINE_TABLE_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   empty,
    input  job_t                   pop_job,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             out_channel,
    output logic [SAMPLE_BITS-1:0] out_sample,
    output logic                   out_last
);

    localparam int unsigned QUARTER = 1 << SINE_TABLE_BITS;
    localparam int unsigned ADDR_W  = SINE_TABLE_BITS + 1;
    localparam int unsigned PROD_W  = 34 + SAMPLE_BITS;
    localparam logic [32:0] ONE_Q30 = 33'h0_4000_0000;
    localparam logic [32:0] HALF    = 33'h0_8000_0000;

    logic [30:0] rom [QUARTER + 1];

    generate
        for (genvar k = 0; k <= QUARTER; k++)
        begin : g_rom
            localparam logic [30:0] ENTRY = sine_entry(k, SINE_TABLE_BITS);
            assign rom[k] = ENTRY;
        end
    endgenerate

    logic                       adv;
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [ADDR_W-1:0]          addr;

    logic        s1_valid_reg;
    job_t        s1_job_reg;
    logic [30:0] s1_mag_reg;

    logic        s2_valid_reg;
    logic [1:0]  s2_channel_reg;
    logic        s2_last_reg;
    logic [32:0] s2_value_reg;
    logic        s2_sh31_reg;
    logic [32:0] value_next;
    logic        sh31_next;

    logic [PROD_W-1:0]      prod;
    logic [PROD_W-1:0]      rounded;
    logic [SAMPLE_BITS-1:0] sample_next;

    logic                   out_valid_reg;
    logic [1:0]             out_channel_reg;
    logic [SAMPLE_BITS-1:0] out_sample_reg;
    logic                   out_last_reg;

    assign adv = !out_valid_reg || out_ready;
    assign pop = adv && !empty;

    assign idx  = pop_job.phase[29 -: SINE_TABLE_BITS];
    assign addr = pop_job.phase[30] ? ADDR_W'(QUARTER) - {1'b0, idx} : {1'b0, idx};

    always_comb
    begin
        value_next = HALF;
        sh31_next  = 1'b1;
        case (s1_job_reg.sel)
            WAVE_SINE:
            begin
                value_next = s1_job_reg.phase[31] ? ONE_Q30 - {2'b0, s1_mag_reg}
                                                  : ONE_Q30 + {2'b0, s1_mag_reg};
            end
            WAVE_TRI:
            begin
                value_next = s1_job_reg.phase[31] ? {1'b0, s1_job_reg.phase} - HALF
                                                  : HALF - {1'b0, s1_job_reg.phase};
            end
            WAVE_SAW:
            begin
                value_next = {1'b0, s1_job_reg.phase};
                sh31_next  = 1'b0;
            end
            default:
            begin
                value_next = s1_job_reg.phase[31] ? 33'd0 : HALF;
            end
        endcase
    end

    // Full scale is 2^SAMPLE_BITS - 1, so the product is a shift and a subtract.
    assign prod    = (PROD_W'(s2_value_reg) << SAMPLE_BITS) - PROD_W'(s2_value_reg);
    assign rounded = prod + (s2_sh31_reg ? PROD_W'(ONE_Q30) : PROD_W'(HALF));
    assign sample_next = s2_sh31_reg ? rounded[31 +: SAMPLE_BITS] : rounded[32 +: SAMPLE_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= pop;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_job_reg      <= pop_job;
            s1_mag_reg      <= rom[addr];
            s2_channel_reg  <= s1_job_reg.channel;
            s2_last_reg     <= s1_job_reg.last;
            s2_value_reg    <= value_next;
            s2_sh31_reg     <= sh31_next;
            out_channel_reg <= s2_channel_reg;
            out_sample_reg  <= sample_next;
            out_last_reg    <= s2_last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_channel = out_channel_reg;
    assign out_sample  = out_sample_reg;
    assign out_last    = out_last_reg;

endmodule

[hw/rtl/multichannel_waveform_generator_top.sv]
// Top level of the multichannel waveform generator.
// Instantiates mwg_front, mwg_queue and mwg_back; depends on mwg_pkg.
//
// Each request on the s_ channel is one sample tick; s_tdata bit 0 is restart, which reloads
// every phase accumulator from the start phases before the tick is generated. For each active
// channel, from channel 0 upward, one request leaves on the m_ channel carrying the channel
// index and a 12-bit sample; m_tlast marks the final active channel of the tick.
// Registers are written on the cfg_ channel (cfg_index selects, cfg_data carries the value);
// cfg_ready is always high and writes are meant to happen while the block is idle.
// The front issues one channel per cycle from the accumulator bank while the queue is not
// full, one job per active channel of the tick; the next tick is taken in the cycle that
// issues the last channel. Each job passes through the queue and then the lookup, shaping
// and scaling stages of the sample pipeline, the first of which pops the queue.
// Reset clears the accumulators, the queue and the pipeline and restores the register
// defaults (one active channel, all sine, zero increments and start phases).
// When the receiver stalls, the sample pipeline holds, the four-entry queue fills, and then
// the front stops issuing and s_tready stays low until room returns.
module multichannel_waveform_generator_top
    import mwg_pkg::*;
#(
    parameter int unsigned CHANNELS        = MWG_CHANNELS,
    parameter int unsigned PHASE_BITS      = MWG_PHASE_BITS,
    parameter int unsigned SAMPLE_BITS     = MWG_SAMPLE_BITS,
    parameter int unsigned SINE_TABLE_BITS = MWG_SINE_TABLE_BITS,
    localparam int unsigned OUT_W          = ((SAMPLE_BITS + 2 + 7) / 8) * 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // restart
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // channel, sample
    output logic             m_tlast,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [63:0]      cfg_data
);

    logic                   q_push;
    job_t                   q_push_job;
    logic                   q_full;
    logic                   q_pop;
    job_t                   q_pop_job;
    logic                   q_empty;
    logic [1:0]             out_channel;
    logic [SAMPLE_BITS-1:0] out_sample;

    assign cfg_ready = 1'b1;

    mwg_front #(
        .CHANNELS   (CHANNELS),
        .PHASE_BITS (PHASE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .tick_valid (s_tvalid),
        .tick_ready (s_tready),
        .restart    (s_tdata[0]),
        .push       (q_push),
        .push_job   (q_push_job),
        .full       (q_full)
    );

    mwg_queue #(
        .DEPTH (MWG_QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (q_pop_job),
        .empty    (q_empty)
    );

    mwg_back #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty       (q_empty),
        .pop_job     (q_pop_job),
        .pop         (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_channel (out_channel),
        .out_sample  (out_sample),
        .out_last    (m_tlast)
    );

    assign m_tdata = OUT_W'({out_sample, out_channel});

endmodule

[hw/rtl/mwg_checker.sv]
// Port-level checks for the multichannel waveform generator, bound to the top level.
// Depends only on the top level's ports.
module mwg_checker #(
    parameter int unsigned CHANNELS = 4,
    parameter int unsigned OUT_W    = 16
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tlast
);

    assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("Output request valid during reset.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("Stalled output request changed.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[1:0] <= 2'(CHANNELS - 1))
        else $error("Output channel beyond the channel count.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[1:0] == 2'(CHANNELS - 1)) |-> m_tlast)
        else $error("Highest channel not marked last.");

endmodule

bind multichannel_waveform_generator_top mwg_checker #(
    .CHANNELS (CHANNELS),
    .OUT_W    (OUT_W)
) u_mwg_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

[sim/multichannel_waveform_generator_top_tb.sv]
// Self-checking testbench for multichannel_waveform_generator_top.
// Drives sample ticks and register writes, predicts every channel sample and compares
// each returned request field by field; depends on mwg_pkg and the top level RTL.
`timescale 1ns / 100ps

module multichannel_waveform_generator_top_tb;
    import mwg_pkg::*;

    localparam int          TABLE_BITS   = MWG_SINE_TABLE_BITS;
    localparam int          QUARTER      = 1 << TABLE_BITS;
    localparam logic [63:0] FULL         = (64'd1 << MWG_SAMPLE_BITS) - 64'd1;
    localparam logic [63:0] ONE_Q30      = 64'd1 << 30;
    localparam logic [63:0] HALF_TURN    = 64'd1 << 31;
    localparam logic [2:0]  CFG_NONE     = 3'd7;
    localparam int          NO_TYPED     = -1;
    localparam int          RANDOM_TICKS = 420;
    localparam int          CALM_FROM    = 360;
    localparam int          PLAN_ROWS    = 45;

    typedef enum logic {ROW_WRITE, ROW_TICK} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [2:0]  index;
        logic [63:0] data;
        logic        restart;
        int          typed;
    } plan_row_t;

    typedef struct {
        logic [1:0]                 channel;
        logic [MWG_SAMPLE_BITS-1:0] sample;
        logic                       last;
    } sample_rec_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    logic [63:0] tone_table [0:QUARTER];
    logic [31:0] phase_acc [0:3];
    logic [31:0] phase_step [0:3];
    logic [2:0]  chan_count;
    logic [7:0]  wave_map;
    logic [63:0] start_word;

    sample_rec_t expected_samples [$];
    int          mismatches = 0;
    bit          calm = 1'b0;
    int          stall_left = 0;
    int          run_left = 0;
    plan_row_t   plan [0:PLAN_ROWS-1];

    multichannel_waveform_generator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] quarter_sine(input int k);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        int          n;
        x    = (64'd1686629713 * 64'(k)) >> TABLE_BITS;
        term = x;
        sum  = x;
        for (n = 1; n <= 6; n++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                sum = (sum >= term) ? sum - term : 64'd0;
            else
                sum = sum + term;
        end
        return (sum > ONE_Q30) ? ONE_Q30 : sum;
    endfunction

    function automatic logic [MWG_SAMPLE_BITS-1:0] wave_sample(input wave_t sel,
                                                               input logic [31:0] p);
        logic [63:0] pw;
        logic [63:0] m;
        logic [63:0] base;
        logic [63:0] d;
        logic [63:0] code;
        int          idx;
        pw = 64'(p);
        case (sel)
            WAVE_SINE:
            begin
                idx  = int'((pw >> (30 - TABLE_BITS)) & 64'(QUARTER - 1));
                m    = p[30] ? tone_table[QUARTER - idx] : tone_table[idx];
                base = p[31] ? ONE_Q30 - m : ONE_Q30 + m;
                code = (base * FULL + ONE_Q30) >> 31;
            end
            WAVE_TRI:
            begin
                d    = (pw < HALF_TURN) ? HALF_TURN - pw : pw - HALF_TURN;
                code = (64'd2 * d * FULL + HALF_TURN) >> 32;
            end
            WAVE_SAW:
                code = (pw * FULL + HALF_TURN) >> 32;
            default:
                code = (pw < HALF_TURN) ? FULL : 64'd0;
        endcase
        return code[MWG_SAMPLE_BITS-1:0];
    endfunction

    function automatic void apply_reg(input logic [2:0] index, input logic [63:0] data);
        case (index)
            CFG_ACTIVE: chan_count = data[2:0];
            CFG_WAVE:   wave_map = data[7:0];
            CFG_INC0:   phase_step[0] = data[31:0];
            CFG_INC1:   phase_step[1] = data[31:0];
            CFG_INC2:   phase_step[2] = data[31:0];
            CFG_INC3:   phase_step[3] = data[31:0];
            CFG_START:  start_word = data;
            default:    ;
        endcase
    endfunction

    function automatic void predict_tick(input logic restart, input int typed);
        int          count;
        int          c;
        sample_rec_t rec;
        count = int'(chan_count);
        if (count < 1)
            count = 1;
        if (count > 4)
            count = 4;
        if (restart)
            for (c = 0; c < 4; c++)
                phase_acc[c] = {start_word[16*c +: 16], 16'h0000};
        for (c = 0; c < count; c++)
        begin
            rec.channel = 2'(c);
            rec.sample  = wave_sample(wave_t'(wave_map[2*c +: 2]), phase_acc[c]);
            rec.last    = (c == count - 1);
            if (c == 0 && typed != NO_TYPED)
                rec.sample = MWG_SAMPLE_BITS'(typed);
            expected_samples.push_back(rec);
            phase_acc[c] = phase_acc[c] + phase_step[c];
        end
    endfunction

    function automatic int pick_gap();
        if (calm || $urandom_range(0, 2) != 0)
            return 0;
        return $urandom_range(1, 9);
    endfunction

    task automatic write_reg(input logic [2:0] index, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(index, data);
    endtask

    task automatic send_tick(input logic restart, input int typed);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, restart};
        do
            @(posedge clk);
        while (!s_tready);
        predict_tick(restart, typed);
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic settle();
        if (expected_samples.size() != 0)
        begin
            s_tvalid <= 1'b0;
            while (expected_samples.size() != 0)
                @(posedge clk);
        end
    endtask

    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'($urandom_range(1, 1 << 20));
            default: return $urandom;
        endcase
    endfunction

    task automatic random_config(input bit all_regs);
        logic [63:0] value;
        int          r;
        for (r = 0; r <= 7; r++)
        begin
            if (all_regs || $urandom_range(0, 1) == 1)
            begin
                case (r)
                    0:       value = 64'($urandom_range(0, 9) < 8 ?
                                         $urandom_range(1, 4) : $urandom_range(0, 7));
                    1:       value = 64'($urandom_range(0, 255));
                    6:       value = ($urandom_range(0, 5) == 0) ?
                                     {64{$urandom_range(0, 1) == 1}} : {$urandom, $urandom};
                    7:       value = {$urandom, $urandom};
                    default: value = 64'(pick_step());
                endcase
                if (r != 7 || $urandom_range(0, 3) == 0)
                    write_reg(3'(r), value);
            end
        end
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (calm)
            m_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (run_left > 0)
        begin
            run_left <= run_left - 1;
            m_tready <= 1'b1;
        end
        else if ($urandom_range(0, 2) == 0)
        begin
            stall_left <= $urandom_range(0, 8);
            m_tready   <= 1'b0;
        end
        else
        begin
            run_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_samples
        sample_rec_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_samples.size() == 0)
            begin
                $error("sample request with nothing expected: channel %0d sample %0d",
                       m_tdata[1:0], m_tdata[13:2]);
                mismatches++;
            end
            else
            begin
                want = expected_samples.pop_front();
                if (m_tdata[1:0] !== want.channel)
                begin
                    $error("channel: expected %0d, got %0d", want.channel, m_tdata[1:0]);
                    mismatches++;
                end
                if (m_tdata[13:2] !== want.sample)
                begin
                    $error("sample: expected %0d, got %0d", want.sample, m_tdata[13:2]);
                    mismatches++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("multichannel_waveform_generator_top_tb: errors");
        $finish;
    end

    initial
    begin
        int k;
        int i;
        int sent;
        int phase_len;
        for (k = 0; k <= QUARTER; k++)
            tone_table[k] = quarter_sine(k);
        for (k = 0; k < 4; k++)
        begin
            phase_acc[k]  = 32'd0;
            phase_step[k] = 32'd0;
        end
        chan_count = 3'd1;
        wave_map   = 8'd0;
        start_word = 64'd0;

        plan = '{
            '{ROW_TICK,  CFG_ACTIVE, 64'd0,                  1'b0, 2048},
            '{ROW_WRITE, CFG_WAVE,   64'h3,                  1'b0, NO_TYPED},
            '{ROW_TICK,  CFG_ACTIVE, 64'd0,                  1'b0, 4095},
            '{ROW_WRITE, CFG_WAVE,   64'h1,                  1'b0, NO_TYPED},
            '{ROW_TICK,  CFG_ACTIVE, 64'd0,                  1'b0, 4095},
            '{ROW_WRITE, CFG_WAVE,   64'h2,                  1'b0, NO_TYPED},
            '{ROW_TICK,  CFG_ACTIVE, 64'd0,                  1'b0, 0},
            '{ROW_WRITE, CFG_START,  64'h8000,               1'b0, NO_TYPED},
            '{ROW_TICK,  CFG_ACTIVE, 64'd0,                  1'b1, 2048},
            '{ROW_WRITE, CFG_WAVE,   64'h3,                  1'b0, NO_TYPED},
            '{ROW_TICK,  CFG_ACTIVE, 64'd0,                  1'b1, 0},
            '{ROW_WRITE, CFG_WAVE,   64'h1,                  1'b0, NO_TYPED},
            '{ROW_TICK,  CFG_ACTIVE, 64'd0,                  1'b1, 0},
            '{ROW_WRITE, CFG_WAVE,   64'h0,                  1'b0, NO_TYPED},
            '{ROW_TICK,  CFG_ACTIVE, 64'd0,                  1'b1, 2048},
            '{ROW_WRITE, CFG_ACTIVE, 64'd4,                  1'b0, NO_TYPED},
            '{ROW_WRITE, CFG_WAVE,   64'hE4,                 1'b0, NO_TYPED},
            '{ROW_WRITE, CFG_INC0,   64'hFFFF_FFFF,          1'b0, NO_TYPED},
            '{ROW_WRITE, CFG_INC1,   64'h1,                  1'b0, NO_TYPED},
            '{ROW_WRITE, CFG_INC2,   64'h8000_0000,          1'b0, NO_TYPED},
            '{ROW_WRITE, CFG_INC3,   64'h0100_0000,          1'b0, NO_TYPED},
            '{ROW_WRITE, CFG_START,  64'hFFFF_C000_4000_0000, 1'b0, NO_TYPED},
            '{ROW_TICK,  CFG_ACTIVE, 64'd0,                  1'b1, NO_TYPED},
            '{ROW_TICK,  CFG_ACTIVE, 64'd0,                  1'b0, NO_TYPED},
            '{ROW_TICK,  CFG_ACTIVE, 64'd0,                  1'b0, NO_TYPED},
            '{ROW_TICK,  CFG_ACTIVE, 64'd0,                  1'b0, NO_TYPED},
            '{ROW_WRITE, CFG_ACTIVE, 64'd0,                  1'b0, NO_TYPED},
            '{ROW_TICK,  CFG_ACTIVE, 64'd0,                  1'b0, NO_TYPED},
            '{ROW_TICK,  CFG_ACTIVE, 64'd0,                  1'b0, NO_TYPED},
            '{ROW_WRITE, CFG_ACTIVE, 64'd7,                  1'b0, NO_TYPED},
            '{ROW_TICK,  CFG_ACTIVE, 64'd0,                  1'b0, NO_TYPED},
            '{ROW_WRITE, CFG_ACTIVE, 64'd2,                  1'b0, NO_TYPED},
            '{ROW_TICK,  CFG_ACTIVE, 64'd0,                  1'b0, NO_TYPED},
            '{ROW_TICK,  CFG_ACTIVE, 64'd0,                  1'b0, NO_TYPED},
            '{ROW_WRITE, CFG_ACTIVE, 64'd4,                  1'b0, NO_TYPED},
            '{ROW_TICK,  CFG_ACTIVE, 64'd0,                  1'b0, NO_TYPED},
            '{ROW_WRITE, CFG_ACTIVE, 64'd1,                  1'b0, NO_TYPED},
            '{ROW_TICK,  CFG_ACTIVE, 64'd0,                  1'b1, NO_TYPED},
            '{ROW_WRITE, CFG_ACTIVE, 64'd4,                  1'b0, NO_TYPED},
            '{ROW_TICK,  CFG_ACTIVE, 64'd0,                  1'b0, NO_TYPED},
            '{ROW_WRITE, CFG_NONE,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, NO_TYPED},
            '{ROW_TICK,  CFG_ACTIVE, 64'd0,                  1'b0, NO_TYPED},
            '{ROW_WRITE, CFG_START,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, NO_TYPED},
            '{ROW_TICK,  CFG_ACTIVE, 64'd0,                  1'b1, NO_TYPED},
            '{ROW_TICK,  CFG_ACTIVE, 64'd0,                  1'b0, NO_TYPED}
        };

        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'd0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_ACTIVE;
        cfg_data  <= 64'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < PLAN_ROWS; i++)
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                if (i > 0 && plan[i-1].kind == ROW_TICK)
                    settle();
                write_reg(plan[i].index, plan[i].data);
                if (i + 1 < PLAN_ROWS && plan[i+1].kind != ROW_WRITE)
                    cfg_valid <= 1'b0;
            end
            else
                send_tick(plan[i].restart, plan[i].typed);
        end

        sent = 0;
        while (sent < RANDOM_TICKS)
        begin
            settle();
            random_config(sent == 0);
            calm      = (sent >= CALM_FROM);
            phase_len = $urandom_range(10, 50);
            for (k = 0; k < phase_len && sent < RANDOM_TICKS; k++)
            begin
                if (!calm && $urandom_range(0, 39) == 0)
                    settle();
                send_tick($urandom_range(0, 7) == 0, NO_TYPED);
                sent++;
            end
        end

        settle();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("multichannel_waveform_generator_top_tb: clean");
        else
            $display("multichannel_waveform_generator_top_tb: errors");
        $finish;
    end

endmodule
